// ===== rtl/fsba_pkg.sv =====
// ----------------------------------------------------------------------------
// Fit strategy block allocator package
// Shared constants and codes for the segment allocator.
// ----------------------------------------------------------------------------
package fsba_pkg;
   localparam int MaxSegments = 64;
   localparam int IdxBits     = $clog2(MaxSegments);
   localparam int CntBits     = $clog2(MaxSegments + 1);
   localparam int OffsetBits  = 32;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_ZERO      = 3'd1;
   localparam logic [2:0] ST_OOM       = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_NULL      = 3'd4;

   localparam logic [1:0] FIT_BEST  = 2'd0;
   localparam logic [1:0] FIT_FIRST = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic [1:0] CSR_FIT   = 2'd0;
   localparam logic [1:0] CSR_POOL  = 2'd1;
   localparam logic [1:0] CSR_SLACK = 2'd2;

   localparam logic [31:0] POOL_RESET  = 32'd67108864;
   localparam logic [15:0] SLACK_RESET = 16'd1024;
endpackage

// ===== rtl/fit_strategy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Fit strategy block allocator
// Segment table allocator with best, first and worst fit and merging frees.
// ----------------------------------------------------------------------------
// The req_ channel takes one allocate or free item at a time; the rsp_ channel
// returns one result item for each. The table is held in a small memory of
// segment entries and walked by one sequencer that owns a single compare
// unit and a single read port.
// An allocate scans the segments, then moves the entries above the chosen one
// one by one when it splits. A free scans until it finds its segment, then
// walks the table again to merge free neighbors, folding each free pair and
// shifting the entries above it down. A zero-size or null item goes straight
// to the done step and from there to the output register.
// The result sits in an output register, so a new item is taken while it
// waits; that item stalls in its last step until the rsp_ side has taken
// the previous result, and rsp_tvalid holds until taken.
// Reset gives one free segment covering the whole pool, best fit and a split
// slack of 1024. Writing pool_bytes reinitializes the table the same way. The
// user must write configuration only while the block is idle (unchecked).
// ----------------------------------------------------------------------------
module fit_strategy_block_allocator
   import fsba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[0], request_bytes[32:1], release_offset[64:33], release_valid[65]
   input  logic [71:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0], granted_offset[34:3], granted_bytes[66:35],
   // bytes_in_use[98:67], segment_total[105:99]
   output logic [111:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_SCANW = 4'd2,
      S_DEC = 4'd3, S_SPL = 4'd4, S_SPLW = 4'd5, S_SPLX = 4'd6,
      S_MRD = 4'd7, S_MRDW = 4'd8, S_MSH = 4'd9, S_MSHW = 4'd10,
      S_DONE = 4'd11, S_FREL = 4'd12;

   logic [31:0] st_mem [MaxSegments];
   logic [31:0] ln_mem [MaxSegments];
   logic [MaxSegments-1:0] busy_ff;

   logic [3:0] state_ff;
   logic [1:0] fit_ff;
   logic [31:0] pool_ff;
   logic [15:0] slack_ff;
   logic [CntBits-1:0] cnt_ff;
   logic [31:0] used_ff;
   logic op_ff, rv_ff;
   logic [31:0] req_ff, roff_ff;
   logic [CntBits-1:0] i_ff, k_ff;
   logic [IdxBits-1:0] rd_addr;
   logic [31:0] rd_st_ff, rd_ln_ff;
   logic found_ff;
   logic [IdxBits-1:0] sel_ff;
   logic [31:0] sel_st_ff, sel_ln_ff;
   logic [31:0] acc_ln_ff;
   logic rv_out_ff;
   logic [2:0] o_st_ff;
   logic [31:0] o_off_ff, o_len_ff;
   logic [111:0] rsp_data_ff;

   logic we;
   logic [IdxBits-1:0] wa;
   logic [31:0] wst, wln;
   logic [32:0] waste, sel_waste, used_sum;
   logic better;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rv_out_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         st_mem[wa] <= wst;
         ln_mem[wa] <= wln;
      end
      rd_st_ff <= st_mem[rd_addr];
      rd_ln_ff <= ln_mem[rd_addr];
   end

   assign waste     = {1'b0, rd_ln_ff} - {1'b0, req_ff};
   assign sel_waste = {1'b0, sel_ln_ff} - {1'b0, req_ff};
   assign used_sum  = {1'b0, used_ff} + {1'b0, req_ff};
   always_comb begin
      if (!found_ff) better = 1'b1;
      else if (fit_ff == FIT_WORST) better = waste > sel_waste;
      else better = waste < sel_waste;
   end

   always_comb begin
      rd_addr = i_ff[IdxBits-1:0];
      we = 1'b0;
      wa = '0;
      wst = rd_st_ff;
      wln = rd_ln_ff;
      unique case (state_ff)
         S_SPL, S_MSH: rd_addr = k_ff[IdxBits-1:0];
         S_SPLW: begin
            we = 1'b1;
            wa = IdxBits'(k_ff + 1'b1);
         end
         S_SPLX: begin
            we = 1'b1;
            wa = IdxBits'(sel_ff + 1'b1);
            wst = sel_st_ff + req_ff;
            wln = sel_ln_ff - req_ff;
         end
         S_MSHW: begin
            we = 1'b1;
            wa = IdxBits'(k_ff - 1'b1);
         end
         S_FREL: begin
            we = 1'b1;
            wa = sel_ff;
            wst = sel_st_ff;
            wln = acc_ln_ff;
         end
         default: ;
      endcase
      if (csr_we && csr_index == CSR_POOL) begin
         we = 1'b1;
         wa = '0;
         wst = '0;
         wln = csr_wdata;
      end
      if (reset) begin
         we = 1'b1;
         wa = '0;
         wst = '0;
         wln = POOL_RESET;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fit_ff <= FIT_BEST;
         pool_ff <= POOL_RESET;
         slack_ff <= SLACK_RESET;
         cnt_ff <= CntBits'(1);
         used_ff <= '0;
         busy_ff <= '0;
         rv_out_ff <= 1'b0;
      end else begin
         if (rv_out_ff && rsp_tready) rv_out_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_FIT: fit_ff <= csr_wdata[1:0];
               CSR_POOL: begin
                  pool_ff <= csr_wdata;
                  cnt_ff <= CntBits'(1);
                  used_ff <= '0;
                  busy_ff <= '0;
               end
               CSR_SLACK: slack_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               op_ff <= req_tdata[0];
               req_ff <= req_tdata[32:1];
               roff_ff <= req_tdata[64:33];
               rv_ff <= req_tdata[65];
               i_ff <= '0;
               found_ff <= 1'b0;
               o_off_ff <= '0;
               o_len_ff <= '0;
               o_st_ff <= ST_OK;
               if (!req_tdata[0]) begin
                  if (req_tdata[32:1] == '0) begin
                     o_st_ff <= ST_ZERO;
                     state_ff <= S_DONE;
                  end else state_ff <= S_SCAN;
               end else if (!req_tdata[65]) begin
                  o_st_ff <= ST_NULL;
                  state_ff <= S_DONE;
               end else state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (!op_ff && used_sum > {1'b0, pool_ff}) begin
                  o_st_ff <= ST_OOM;
                  state_ff <= S_DONE;
               end else if (i_ff >= cnt_ff) state_ff <= S_DEC;
               else state_ff <= S_SCANW;
            end
            S_SCANW: begin
               i_ff <= i_ff + 1'b1;
               state_ff <= S_SCAN;
               if (!op_ff) begin
                  if (!busy_ff[i_ff[IdxBits-1:0]] && rd_ln_ff >= req_ff && better) begin
                     found_ff <= 1'b1;
                     sel_ff <= i_ff[IdxBits-1:0];
                     sel_st_ff <= rd_st_ff;
                     sel_ln_ff <= rd_ln_ff;
                     if (fit_ff == FIT_FIRST) state_ff <= S_DEC;
                  end
               end else if (busy_ff[i_ff[IdxBits-1:0]] && rd_st_ff == roff_ff) begin
                  found_ff <= 1'b1;
                  sel_ff <= i_ff[IdxBits-1:0];
                  sel_st_ff <= rd_st_ff;
                  sel_ln_ff <= rd_ln_ff;
                  state_ff <= S_DEC;
               end
            end
            S_DEC: begin
               if (!found_ff) begin
                  o_st_ff <= op_ff ? ST_NOT_FOUND : ST_OOM;
                  state_ff <= S_DONE;
               end else if (!op_ff) begin
                  busy_ff[sel_ff] <= 1'b1;
                  o_off_ff <= sel_st_ff;
                  if ({1'b0, sel_ln_ff} > used_sum - {1'b0, used_ff} + {17'd0, slack_ff}
                      && cnt_ff < CntBits'(MaxSegments)) begin
                     o_len_ff <= req_ff;
                     used_ff <= used_ff + req_ff;
                     k_ff <= cnt_ff - 1'b1;
                     state_ff <= S_SPL;
                  end else begin
                     o_len_ff <= sel_ln_ff;
                     used_ff <= used_ff + sel_ln_ff;
                     state_ff <= S_DONE;
                  end
               end else begin
                  busy_ff[sel_ff] <= 1'b0;
                  used_ff <= used_ff - sel_ln_ff;
                  o_len_ff <= sel_ln_ff;
                  i_ff <= '0;
                  state_ff <= S_MRD;
               end
            end
            S_SPL: begin
               if (k_ff == {1'b0, sel_ff}) state_ff <= S_SPLX;
               else state_ff <= S_SPLW;
            end
            S_SPLW: begin
               busy_ff[IdxBits'(k_ff + 1'b1)] <= busy_ff[k_ff[IdxBits-1:0]];
               k_ff <= k_ff - 1'b1;
               state_ff <= S_SPL;
            end
            S_SPLX: begin
               busy_ff[IdxBits'(sel_ff + 1'b1)] <= 1'b0;
               cnt_ff <= cnt_ff + 1'b1;
               sel_st_ff <= sel_st_ff;
               state_ff <= S_FREL;
               acc_ln_ff <= req_ff;
            end
            // Merge: walk i; on a free pair fold i+1 into i and shift down.
            S_MRD: begin
               if (i_ff + 1'b1 >= cnt_ff) state_ff <= S_DONE;
               else state_ff <= S_MRDW;
            end
            S_MRDW: begin
               if (!busy_ff[i_ff[IdxBits-1:0]] && !busy_ff[IdxBits'(i_ff + 1'b1)]) begin
                  sel_ff <= i_ff[IdxBits-1:0];
                  sel_st_ff <= rd_st_ff;
                  acc_ln_ff <= rd_ln_ff;
                  k_ff <= i_ff + 1'b1;
                  state_ff <= S_MSH;
               end else begin
                  i_ff <= i_ff + 1'b1;
                  state_ff <= S_MRD;
               end
            end
            S_MSH: state_ff <= S_MSHW;
            S_MSHW: begin
               if (k_ff == CntBits'(sel_ff) + 1'b1) begin
                  acc_ln_ff <= acc_ln_ff + rd_ln_ff;
                  state_ff <= S_MSH;
                  k_ff <= k_ff + 1'b1;
                  if (k_ff + 1'b1 >= cnt_ff) state_ff <= S_FREL;
               end else begin
                  busy_ff[IdxBits'(k_ff - 1'b1)] <= busy_ff[k_ff[IdxBits-1:0]];
                  k_ff <= k_ff + 1'b1;
                  if (k_ff + 1'b1 >= cnt_ff) state_ff <= S_FREL;
                  else state_ff <= S_MSH;
               end
            end
            S_FREL: begin
               if (op_ff) begin
                  cnt_ff <= cnt_ff - 1'b1;
                  state_ff <= S_MRD;
               end else state_ff <= S_DONE;
            end
            S_DONE: if (!rv_out_ff) begin
               rv_out_ff <= 1'b1;
               rsp_data_ff <= {6'd0, cnt_ff, used_ff, o_len_ff, o_off_ff, o_st_ff};
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 && cnt_ff <= CntBits'(MaxSegments))
      else $error("segment count out of range");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE)
      else $error("ready outside idle");
   a_oom_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_OK |-> rsp_tdata[34:3] == '0)
      else $error("offset on failure");
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit strategy block allocator testbench
// Drives allocate and free items through the request stream, predicts every
// result from a segment table kept alongside the block, and compares each
// result field by field while the pool size, fit strategy and slack change.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [2:0]  status;
   logic [31:0] granted_offset;
   logic [31:0] granted_bytes;
   logic [31:0] bytes_in_use;
   logic [6:0]  segment_total;
} alloc_result_t;

class alloc_scoreboard;
   logic [1:0]    fit;
   logic [31:0]   pool;
   logic [15:0]   slack;
   logic [31:0]   seg_start [fsba_pkg::MaxSegments];
   logic [31:0]   seg_len [fsba_pkg::MaxSegments];
   bit            seg_busy [fsba_pkg::MaxSegments];
   int unsigned   seg_count;
   logic [31:0]   busy_bytes;
   alloc_result_t expected_results [$];
   logic [31:0]   live_offsets [$];
   int unsigned   mismatches;
   int unsigned   status_seen [5];
   int unsigned   peak_segments;

   function void clear_table();
      foreach (seg_busy[i]) begin
         seg_busy[i] = 0;
         seg_start[i] = '0;
         seg_len[i] = '0;
      end
      seg_len[0] = pool;
      seg_count = 1;
      busy_bytes = '0;
      live_offsets.delete();
   endfunction

   function void write_reg(logic [1:0] idx, logic [31:0] value);
      if (idx == fsba_pkg::CSR_FIT) begin
         fit = value[1:0];
      end else if (idx == fsba_pkg::CSR_POOL) begin
         pool = value;
         clear_table();
      end else if (idx == fsba_pkg::CSR_SLACK) begin
         slack = value[15:0];
      end
   endfunction

   function new();
      mismatches = 0;
      peak_segments = 1;
      fit = fsba_pkg::FIT_BEST;
      pool = fsba_pkg::POOL_RESET;
      slack = fsba_pkg::SLACK_RESET;
      clear_table();
   endfunction

   function int pick_free_segment(longint unsigned req);
      int chosen;
      longint unsigned chosen_waste, waste;
      chosen = -1;
      chosen_waste = 0;
      for (int i = 0; i < seg_count; i++) begin
         if (seg_busy[i] || longint'(seg_len[i]) < req) continue;
         waste = longint'(seg_len[i]) - req;
         if (fit == fsba_pkg::FIT_FIRST) return i;
         if (chosen < 0 || (fit == fsba_pkg::FIT_WORST ? waste > chosen_waste
                                                       : waste < chosen_waste)) begin
            chosen = i;
            chosen_waste = waste;
         end
      end
      return chosen;
   endfunction

   function void merge_free_runs();
      int unsigned i;
      i = 0;
      while (i + 1 < seg_count) begin
         if (!seg_busy[i] && !seg_busy[i + 1]) begin
            seg_len[i] = seg_len[i] + seg_len[i + 1];
            for (int k = i + 1; k + 1 < seg_count; k++) begin
               seg_start[k] = seg_start[k + 1];
               seg_len[k] = seg_len[k + 1];
               seg_busy[k] = seg_busy[k + 1];
            end
            seg_count--;
         end else begin
            i++;
         end
      end
   endfunction

   function void note_item(logic [71:0] data);
      alloc_result_t r;
      longint unsigned req;
      int p;
      logic [31:0] off;
      r = '0;
      req = data[32:1];
      off = data[64:33];
      if (data[0] == 1'b0) begin
         if (req == 0) begin
            r.status = fsba_pkg::ST_ZERO;
         end else if (longint'(busy_bytes) + req > longint'(pool)) begin
            r.status = fsba_pkg::ST_OOM;
         end else begin
            p = pick_free_segment(req);
            if (p < 0) begin
               r.status = fsba_pkg::ST_OOM;
            end else begin
               if (longint'(seg_len[p]) > req + slack &&
                   seg_count < fsba_pkg::MaxSegments) begin
                  for (int k = seg_count; k > p + 1; k--) begin
                     seg_start[k] = seg_start[k - 1];
                     seg_len[k] = seg_len[k - 1];
                     seg_busy[k] = seg_busy[k - 1];
                  end
                  seg_start[p + 1] = seg_start[p] + req[31:0];
                  seg_len[p + 1] = seg_len[p] - req[31:0];
                  seg_busy[p + 1] = 0;
                  seg_len[p] = req[31:0];
                  seg_count++;
               end
               seg_busy[p] = 1;
               busy_bytes = busy_bytes + seg_len[p];
               r.status = fsba_pkg::ST_OK;
               r.granted_offset = seg_start[p];
               r.granted_bytes = seg_len[p];
               live_offsets.insert(live_offsets.size(), seg_start[p]);
            end
         end
      end else if (data[65] == 1'b0) begin
         r.status = fsba_pkg::ST_NULL;
      end else begin
         r.status = fsba_pkg::ST_NOT_FOUND;
         for (int i = 0; i < seg_count; i++) begin
            if (seg_busy[i] && seg_start[i] == off) begin
               seg_busy[i] = 0;
               busy_bytes = busy_bytes - seg_len[i];
               r.granted_bytes = seg_len[i];
               r.status = fsba_pkg::ST_OK;
               merge_free_runs();
               foreach (live_offsets[j]) begin
                  if (live_offsets[j] == off) begin
                     live_offsets.delete(j);
                     break;
                  end
               end
               break;
            end
         end
      end
      r.bytes_in_use = busy_bytes;
      r.segment_total = seg_count[6:0];
      if (seg_count > peak_segments) peak_segments = seg_count;
      status_seen[r.status]++;
      expected_results.insert(expected_results.size(), r);
   endfunction

   function void check_result(logic [111:0] data);
      alloc_result_t got, want;
      got.status = data[2:0];
      got.granted_offset = data[34:3];
      got.granted_bytes = data[66:35];
      got.bytes_in_use = data[98:67];
      got.segment_total = data[105:99];
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result item %p", got);
         return;
      end
      want = expected_results.pop_front();
      if (got != want) begin
         mismatches++;
         if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
   endfunction
endclass

module testbench;
   import fsba_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [71:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [111:0] rsp_tdata;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [31:0]  csr_wdata;

   alloc_scoreboard alloc_sb;
   int unsigned send_idle_pct, recv_idle_pct;
   logic        recv_hold;
   int unsigned quiet_cycles;

   fit_strategy_block_allocator u_top (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      alloc_sb.write_reg(idx, value);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_item(logic op, logic [31:0] bytes, logic [31:0] off, logic rv);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, rv, off, bytes, op};
      do @(posedge clock); while (!req_tready);
      alloc_sb.note_item(req_tdata);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (alloc_sb.expected_results.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic random_items(int count);
      int unsigned roll;
      longint unsigned top;
      logic [31:0] off;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         top = (longint'(alloc_sb.pool) >> 5) + 1;
         if (roll < 62) begin
            send_item(1'b0, 32'($urandom_range(top > 32'hFFFF_FFFF ? 32'hFFFF_FFFF
                                                                  : 32'(top), 1)),
                      $urandom, 1'b0);
         end else if (roll < 68) begin
            send_item(1'b0, $urandom_range(alloc_sb.pool, 1), $urandom, 1'b0);
         end else if (roll < 92 && alloc_sb.live_offsets.size() != 0) begin
            off = alloc_sb.live_offsets[$urandom_range(alloc_sb.live_offsets.size() - 1)];
            send_item(1'b1, $urandom, off, 1'b1);
         end else if (roll < 95) begin
            send_item(1'b1, $urandom, $urandom, 1'b1);
         end else if (roll < 97) begin
            send_item(1'b1, $urandom, $urandom, 1'b0);
         end else begin
            send_item(1'b0, $urandom_range(1) ? 32'd0 : $urandom, $urandom, 1'b0);
         end
      end
   endtask

   task automatic set_config(logic [1:0] fit, logic [31:0] pool, logic [15:0] slack);
      drain();
      write_csr(CSR_FIT, {30'b0, fit});
      write_csr(CSR_SLACK, {16'b0, slack});
      write_csr(CSR_POOL, pool);
   endtask

   // Result side: take results with random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) alloc_sb.check_result(rsp_tdata);
         rsp_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 20000) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      alloc_sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      recv_hold = 1'b0;
      send_idle_pct = 23;
      recv_idle_pct = 61;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: zero size, over budget, null and unknown frees, then allocations and frees.
      send_item(1'b0, 32'd0, 32'hFFFF_FFFF, 1'b1);
      send_item(1'b0, 32'hFFFF_FFFF, 32'd0, 1'b0);
      send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_item(1'b1, 32'd0, 32'hFFFF_FFFF, 1'b1);
      send_item(1'b1, 32'd0, 32'd0, 1'b1);
      send_item(1'b0, 32'd1, 32'd0, 1'b0);
      send_item(1'b1, 32'd0, 32'd0, 1'b1);
      send_item(1'b1, 32'd0, 32'd0, 1'b1);
      send_item(1'b0, POOL_RESET, 32'd0, 1'b0);
      send_item(1'b0, 32'd1, 32'd0, 1'b0);
      send_item(1'b1, 32'd0, 32'd0, 1'b1);
      send_item(1'b0, 32'd100, 32'd0, 1'b0);
      send_item(1'b0, 32'd5000, 32'd0, 1'b0);
      send_item(1'b0, 32'd300, 32'd0, 1'b0);
      send_item(1'b1, 32'd0, 32'd100, 1'b1);
      send_item(1'b1, 32'd0, 32'd0, 1'b1);
      send_item(1'b0, 32'd50, 32'd0, 1'b0);
      // Worst fit with an exact fit and ties.
      set_config(FIT_WORST, 32'd300, 16'd0);
      send_item(1'b0, 32'd100, 32'd0, 1'b0);
      send_item(1'b0, 32'd100, 32'd0, 1'b0);
      send_item(1'b0, 32'd100, 32'd0, 1'b0);
      send_item(1'b1, 32'd0, 32'd0, 1'b1);
      send_item(1'b1, 32'd0, 32'd200, 1'b1);
      send_item(1'b0, 32'd100, 32'd0, 1'b0);
      send_item(1'b0, 32'd101, 32'd0, 1'b0);

      set_config(FIT_BEST, POOL_RESET, SLACK_RESET);
      random_items(60);
      set_config(FIT_FIRST, 32'd4096, 16'd0);
      random_items(130);
      send_idle_pct = 61;
      recv_idle_pct = 23;
      set_config(FIT_WORST, 32'hFFFF_FFFF, 16'hFFFF);
      random_items(100);
      set_config(2'd3, 32'd3000, 16'd16);
      random_items(100);
      set_config(FIT_BEST, 32'd1, 16'd0);
      random_items(20);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(FIT_WORST, 32'd2048, 16'd0);
      random_items(100);
      set_config(FIT_FIRST, 32'd0, 16'd0);
      random_items(15);
      set_config(FIT_BEST, 32'd8192, 16'd3);
      fork
         begin
            recv_hold <= 1'b1;
            repeat (400) @(posedge clock);
            recv_hold <= 1'b0;
         end
         random_items(125);
      join
      drain();

      $display("Covered ok %0d, zero size %0d, out of memory %0d, not found %0d, null %0d;",
               alloc_sb.status_seen[ST_OK], alloc_sb.status_seen[ST_ZERO],
               alloc_sb.status_seen[ST_OOM], alloc_sb.status_seen[ST_NOT_FOUND],
               alloc_sb.status_seen[ST_NULL]);
      $display("peak table size %0d segments over all four strategy codes, %0d mismatches.",
               alloc_sb.peak_segments, alloc_sb.mismatches);
      if (alloc_sb.mismatches == 0 && alloc_sb.expected_results.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
